@@ hw/rtl/bdcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcc_pkg
// Shared types and constants for the button debounce and click counter core.
// ----------------------------------------------------------------------------
package bdcc_pkg;

    localparam int unsigned TIME_WIDTH_DEF = 32;
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned CFG_ADDR_W     = 1;
    localparam int unsigned TOTAL_W        = 8;
    localparam int unsigned HOLD_W         = 32;
    localparam int unsigned IN_DATA_W      = 8;
    localparam int unsigned OUT_DATA_W     = 40;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd500;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW   = 1'b1;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_EDGE = 1'b1;

    typedef enum logic [1:0] {
        KIND_COUNT = 2'd0,
        KIND_DOWN  = 2'd1,
        KIND_UP    = 2'd2
    } t_kind;

    typedef struct packed {
        logic mode;
        logic level;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [TOTAL_W-1:0] total;
        logic [HOLD_W-1:0]  hold;
    } t_result;

endpackage

@@ hw/rtl/button_debounce_click_counter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_click_counter_core
// Button debouncer with multi-click counting and hold timing.
//
// The slave stream carries ticks (tuser 0) and pin edges (tuser 1, level in
// tdata bit 0). Each item gives at most one result on the master stream:
// a press count report, button down or button up with the hold time.
// An item passes the input register, then the state logic writes the result
// register, which drives the master stream. One item is taken every cycle
// unless a result must wait on a full result register, as set by the single
// state update per cycle.
// When the receiver stalls, items that give no result still pass; an item
// that gives one waits in the input register while the result register is
// full, and s_axis_tready falls only then. Configuration writes on the plain
// write port apply at once; the user must make them while the block is idle,
// which the block does not enforce. Synchronous active-low reset clears the
// clock, timers, counts and both registers and loads debounce 50 ms and window 500 ms.
// ----------------------------------------------------------------------------
module button_debounce_click_counter_core #(
    parameter int unsigned TIME_WIDTH = bdcc_pkg::TIME_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdcc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bdcc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bdcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // pin_level, zero fill
    input  logic                            s_axis_tuser,   // mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bdcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // press_total, hold_ms
    output logic [1:0]                      m_axis_tuser    // event_kind
);

    bdcc_pkg::t_item   in_item;
    bdcc_pkg::t_item   item;
    bdcc_pkg::t_result res;
    bdcc_pkg::t_result out_res;
    logic              item_valid;
    logic              advance;
    logic              res_valid;
    logic              out_ready;

    assign in_item.mode  = s_axis_tuser;
    assign in_item.level = s_axis_tdata[0];

    bdcc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    bdcc_engine #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (item_valid),
        .i_item      (item),
        .i_out_ready (out_ready),
        .o_advance   (advance),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bdcc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (out_ready),
        .i_res   (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {out_res.hold, out_res.total};

endmodule

@@ hw/rtl/bdcc_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcc_in_reg
// Input register: captures one item and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module bdcc_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bdcc_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output bdcc_pkg::t_item o_item
);

    logic            r_valid;
    bdcc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ hw/rtl/bdcc_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcc_engine
// Debounce, press counting window and hold timing state with result logic.
// ----------------------------------------------------------------------------
module bdcc_engine #(
    parameter int unsigned TIME_WIDTH = bdcc_pkg::TIME_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdcc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bdcc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_valid,
    input  bdcc_pkg::t_item                 i_item,
    input  logic                            i_out_ready,
    output logic                            o_advance,
    output logic                            o_res_valid,
    output bdcc_pkg::t_result               o_res
);

    logic [bdcc_pkg::CFG_W-1:0]   r_debounce;
    logic [bdcc_pkg::CFG_W-1:0]   r_window_len;
    logic [TIME_WIDTH-1:0]        r_now;
    logic [TIME_WIDTH-1:0]        r_last;
    logic [TIME_WIDTH-1:0]        r_hold_start;
    logic                         r_holding;
    logic                         r_prev_level;
    logic [bdcc_pkg::TOTAL_W-1:0] r_edge_count;
    logic [bdcc_pkg::CFG_W-1:0]   r_window_left;
    logic                         r_window_on;

    logic [TIME_WIDTH-1:0]        n_now;
    logic [TIME_WIDTH-1:0]        n_last;
    logic [TIME_WIDTH-1:0]        n_hold_start;
    logic                         n_holding;
    logic                         n_prev_level;
    logic [bdcc_pkg::TOTAL_W-1:0] n_edge_count;
    logic [bdcc_pkg::CFG_W-1:0]   n_window_left;
    logic                         n_window_on;

    logic [TIME_WIDTH-1:0]        elapsed;
    logic [TIME_WIDTH-1:0]        held;
    logic [bdcc_pkg::HOLD_W-1:0]  held_sat;
    logic [bdcc_pkg::CFG_W-1:0]   left_dec;
    logic                         res_valid;
    bdcc_pkg::t_result            res;

    assign elapsed  = r_now - r_last;
    assign held     = r_now - r_hold_start;
    assign held_sat = ((held >> bdcc_pkg::HOLD_W) != '0) ? '1 : bdcc_pkg::HOLD_W'(held);
    assign left_dec = (r_window_left != '0) ? r_window_left - 1'b1 : r_window_left;

    always_comb begin
        n_now         = r_now;
        n_last        = r_last;
        n_hold_start  = r_hold_start;
        n_holding     = r_holding;
        n_prev_level  = r_prev_level;
        n_edge_count  = r_edge_count;
        n_window_left = r_window_left;
        n_window_on   = r_window_on;
        res_valid     = 1'b0;
        res.kind      = bdcc_pkg::KIND_COUNT;
        res.total     = '0;
        res.hold      = '0;
        if (i_item.mode == bdcc_pkg::MODE_TICK) begin
            n_now = r_now + 1'b1;
            if (r_window_on) begin
                n_window_left = left_dec;
                if (left_dec == '0) begin
                    n_window_on  = 1'b0;
                    n_edge_count = '0;
                    res_valid    = 1'b1;
                    res.total    = r_edge_count;
                end
            end
        end else if (elapsed > TIME_WIDTH'(r_debounce)) begin
            if (!r_window_on) begin
                n_window_on   = 1'b1;
                n_window_left = (r_window_len == '0) ? bdcc_pkg::CFG_W'(1) : r_window_len;
            end
            n_edge_count = r_edge_count + 1'b1;
            n_last       = r_now;
            if (i_item.level == r_prev_level) begin
                n_prev_level = 1'b0;
            end else begin
                n_prev_level = i_item.level;
                if (!i_item.level) begin
                    if (r_holding) begin
                        n_holding    = 1'b0;
                        n_hold_start = '0;
                        res_valid    = 1'b1;
                        res.kind     = bdcc_pkg::KIND_UP;
                        res.hold     = held_sat;
                    end
                end else begin
                    n_hold_start = r_now;
                    n_holding    = 1'b1;
                    res_valid    = 1'b1;
                    res.kind     = bdcc_pkg::KIND_DOWN;
                end
            end
        end
    end

    assign o_advance   = i_valid && (!res_valid || i_out_ready);
    assign o_res_valid = i_valid && res_valid;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= bdcc_pkg::DEBOUNCE_RESET;
            r_window_len  <= bdcc_pkg::WINDOW_RESET;
            r_now         <= '0;
            r_last        <= '0;
            r_hold_start  <= '0;
            r_holding     <= 1'b0;
            r_prev_level  <= 1'b0;
            r_edge_count  <= '0;
            r_window_left <= '0;
            r_window_on   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    bdcc_pkg::REG_DEBOUNCE: r_debounce   <= i_cfg_wdata;
                    bdcc_pkg::REG_WINDOW:   r_window_len <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_advance) begin
                r_now         <= n_now;
                r_last        <= n_last;
                r_hold_start  <= n_hold_start;
                r_holding     <= n_holding;
                r_prev_level  <= n_prev_level;
                r_edge_count  <= n_edge_count;
                r_window_left <= n_window_left;
                r_window_on   <= n_window_on;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && o_res_valid && o_res.kind == bdcc_pkg::KIND_COUNT)
        |=> (!r_window_on && r_edge_count == '0))
        else $error("count report did not close the window");

    a_down_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && o_res_valid && o_res.kind == bdcc_pkg::KIND_DOWN)
        |=> (r_holding && r_hold_start == $past(r_now)))
        else $error("button down did not start a hold");

    a_idle_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_holding |-> (r_hold_start == '0))
        else $error("hold start set without a hold");

    a_up_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == bdcc_pkg::KIND_UP) |-> r_holding)
        else $error("button up without a hold");
`endif

endmodule

@@ hw/rtl/bdcc_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcc_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module bdcc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bdcc_pkg::t_result i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output bdcc_pkg::t_result o_res
);

    logic              r_valid;
    bdcc_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

@@ sim/bdcc_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcc_event_checker
// Watches the register port and both streams of the click counter core. It
// keeps its own copy of the debounce state and predicts the event that each
// accepted input item should give. Each result item is checked field by field
// against the oldest pending event, and mismatches are counted for the top.
// ----------------------------------------------------------------------------
module bdcc_event_checker
    import bdcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_in_user,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_DATA_W-1:0] i_out_data,
    input  logic [1:0]            i_out_user,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [CFG_W-1:0]          debounce_ms;
    logic [CFG_W-1:0]          window_len;
    logic [TIME_WIDTH_DEF-1:0] now_ms;
    logic [TIME_WIDTH_DEF-1:0] last_accept_ms;
    logic [TIME_WIDTH_DEF-1:0] hold_start_ms;
    logic                      holding;
    logic                      prev_level;
    logic [TOTAL_W-1:0]        edge_count;
    logic [CFG_W-1:0]          window_left;
    logic                      window_on;

    t_result expected_events[$];
    t_result want;
    int      fail_total = 0;

    task automatic push_event(input t_kind kind, input logic [TOTAL_W-1:0] total,
                              input logic [HOLD_W-1:0] hold);
        t_result ev;
        ev.kind  = kind;
        ev.total = total;
        ev.hold  = hold;
        expected_events.push_back(ev);
    endtask

    task automatic step_debouncer(input logic mode, input logic level);
        logic [TIME_WIDTH_DEF-1:0] elapsed;
        elapsed = now_ms - last_accept_ms;
        if (mode == MODE_TICK) begin
            now_ms = now_ms + 1'b1;
            if (window_on) begin
                if (window_left != 0) window_left = window_left - 1'b1;
                if (window_left == 0) begin
                    window_on = 1'b0;
                    push_event(KIND_COUNT, edge_count, '0);
                    edge_count = '0;
                end
            end
        end else if (elapsed > debounce_ms) begin
            if (!window_on) begin
                window_on   = 1'b1;
                window_left = (window_len == 0) ? 16'd1 : window_len;
            end
            edge_count     = edge_count + 1'b1;
            last_accept_ms = now_ms;
            if (level == prev_level) begin
                prev_level = 1'b0;
            end else begin
                prev_level = level;
                if (level) begin
                    hold_start_ms = now_ms;
                    holding       = 1'b1;
                    push_event(KIND_DOWN, '0, '0);
                end else if (holding) begin
                    // time width equals the hold field here, so no saturation
                    push_event(KIND_UP, '0, HOLD_W'(now_ms - hold_start_ms));
                    holding       = 1'b0;
                    hold_start_ms = '0;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            debounce_ms    = DEBOUNCE_RESET;
            window_len     = WINDOW_RESET;
            now_ms         = '0;
            last_accept_ms = '0;
            hold_start_ms  = '0;
            holding        = 1'b0;
            prev_level     = 1'b0;
            edge_count     = '0;
            window_left    = '0;
            window_on      = 1'b0;
            expected_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_DEBOUNCE: debounce_ms = i_cfg_wdata;
                    REG_WINDOW:   window_len  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) step_debouncer(i_in_user, i_in_data[0]);
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result item: expected none, actual kind %0d total %0d hold %0d",
                             $time, i_out_user, i_out_data[TOTAL_W-1:0],
                             i_out_data[TOTAL_W +: HOLD_W]);
                    fail_total++;
                end else begin
                    want = expected_events.pop_front();
                    if (i_out_user !== want.kind) begin
                        $display("%0t: event_kind mismatch: expected %0d actual %0d",
                                 $time, want.kind, i_out_user);
                        fail_total++;
                    end
                    if (i_out_data[TOTAL_W-1:0] !== want.total) begin
                        $display("%0t: press_total mismatch: expected %0d actual %0d",
                                 $time, want.total, i_out_data[TOTAL_W-1:0]);
                        fail_total++;
                    end
                    if (i_out_data[TOTAL_W +: HOLD_W] !== want.hold) begin
                        $display("%0t: hold_ms mismatch: expected %0d actual %0d",
                                 $time, want.hold, i_out_data[TOTAL_W +: HOLD_W]);
                        fail_total++;
                    end
                end
            end
        end
        o_pending    <= expected_events.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ sim/tb_button_debounce_click_counter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_click_counter_core
// Stimulus and verdict for the button debounce and click counter core.
//
// Drives ticks and pin edges in bursts with random gaps while the result side
// stalls on its own pattern, including one long hold-off that backs up the
// input. Phases run the default, extreme and several small register settings,
// starting with directed edge cases and then mostly well-formed press
// sequences mixed with bounce noise. Checking is done by bdcc_event_checker.
// ----------------------------------------------------------------------------
module tb_button_debounce_click_counter_core;
    import bdcc_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_STALL    = 400;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = MODE_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int burst_left   = 0;
    int hold_token   = 0;
    int hold_taken   = 0;
    int stall_left   = 0;
    int pattern_left = 0;
    int ready_style  = 0;
    int debounce_now = int'(DEBOUNCE_RESET);
    logic pin_state  = 1'b0;

    button_debounce_click_counter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bdcc_event_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: long hold-off on request, otherwise a changing ready pattern
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_token != hold_taken) begin
            hold_taken    <= hold_token;
            stall_left    <= LONG_STALL;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left <= $urandom_range(16, 96);
                ready_style  <= $urandom_range(0, 3);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (ready_style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_item(input logic mode, input logic level);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, level};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_item(MODE_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic press_edge(input logic level);
        send_item(MODE_EDGE, level);
    endtask

    task automatic wait_for_quiet();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] window);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_DEBOUNCE;
        i_cfg_wdata <= debounce;
        @(posedge i_clk);
        i_cfg_addr  <= REG_WINDOW;
        i_cfg_wdata <= window;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        debounce_now = int'(debounce);
    endtask

    // random ticks, toggling presses often spaced past the debounce time, plus bounce
    task automatic random_phase(input int n);
        int   pick;
        logic lvl;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_item(MODE_TICK, 1'($urandom_range(0, 1)));
            end else if (pick < 88) begin
                if ($urandom_range(0, 1)) tick_run(debounce_now + 1);
                lvl = ~pin_state;
                press_edge(lvl);
                pin_state = lvl;
            end else begin
                press_edge(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: early edge, edge right at the debounce time, first press
        press_edge(1'b1);
        tick_run(int'(DEBOUNCE_RESET));
        press_edge(1'b1);
        send_item(MODE_TICK, 1'b1);
        press_edge(1'b1);
        wait_for_quiet();

        // short debounce and zero window while the default window still runs
        set_config(16'd2, 16'd0);
        press_edge(1'b1);
        tick_run(2);
        press_edge(1'b1);
        send_item(MODE_TICK, 1'b0);
        press_edge(1'b1);
        tick_run(3);
        press_edge(1'b1);
        press_edge(1'b0);
        tick_run(3);
        press_edge(1'b0);
        tick_run(3);
        press_edge(1'b0);
        tick_run(3);
        press_edge(1'b1);
        tick_run(3);
        press_edge(1'b1);
        tick_run(3);
        press_edge(1'b1);
        wait_for_quiet();

        set_config(16'd3, 16'd20);
        hold_token <= hold_token + 1;
        random_phase(100);
        wait_for_quiet();

        set_config(16'd0, 16'd1);
        random_phase(80);
        wait_for_quiet();

        set_config(16'd7, 16'd0);
        random_phase(60);
        wait_for_quiet();

        set_config(16'd12, 16'd60);
        random_phase(40);
        wait_for_quiet();

        // widest debounce and window: edges stay rejected
        set_config(16'hFFFF, 16'hFFFF);
        press_edge(1'b1);
        tick_run(3);
        press_edge(1'b0);
        wait_for_quiet();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule
